// ===== hdl/tabg_pkg.sv =====
// tabg_pkg: shared types and constants of the turbo autofire button gate
// depends on nothing; used by the lane, the top level and the testbench
package tabg_pkg;

    // lanes that work side by side, one button each per pass
    localparam int LANES = 8;
    // width of one frame number and one press frame
    localparam int FRAME_W = 64;
    // configuration register indexes
    localparam logic [1:0] CFG_TAP_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_AUTO_TAP     = 2'd1;
    localparam logic [1:0] CFG_AUTO_HOLD    = 2'd2;
    // operation codes
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // sequencer strobes to every lane
    typedef struct packed {
        logic clr;
        logic ld;
        logic step;
    } t_lane_ctl;

    // what one lane found for its current button
    typedef struct packed {
        logic out_bit;
        logic toggled;
        logic turbo;
    } t_lane_res;

endpackage

// ===== hdl/tabg_ram.sv =====
// tabg_ram: generic single write, single read RAM with registered read data
// depends on nothing
module tabg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/tabg_lane.sv =====
// tabg_lane: one button lane: press frame bank, held and turbo bits, bit-serial modulo
// depends on tabg_pkg and tabg_ram
module tabg_lane #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tabg_pkg::t_lane_ctl  i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic                 i_btn,
    input  logic [63:0]          i_now,
    input  logic                 i_mod_held,
    input  logic                 i_mod_just,
    input  logic [7:0]           i_tap,
    input  logic                 i_auto_tap,
    input  logic                 i_auto_hold,
    output tabg_pkg::t_lane_res  o_res
);
    import tabg_pkg::*;

    logic [DEPTH-1:0]   r_held;
    logic [DEPTH-1:0]   r_turbo;
    logic [FRAME_W-1:0] w_pf;
    logic [FRAME_W-1:0] r_div;
    logic [FRAME_W-1:0] n_div;
    logic [7:0]         r_rem;
    logic               r_drive;
    logic               r_tog;
    logic               r_turbo_bit;
    logic               r_bit;
    logic               w_upd;
    logic               w_turbo_new;
    logic [8:0]         w_period;
    logic [8:0]         w_trial;

    // press frame bank; the held bit says whether an entry is live
    tabg_ram #(.WIDTH(FRAME_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.ld && w_upd),
        .i_waddr(i_addr),
        .i_wdata(i_now),
        .i_raddr(i_addr),
        .o_rdata(w_pf)
    );

    // new press or modifier edge restarts the button, modifier toggles turbo
    always_comb begin
        w_upd       = i_btn && (!r_held[i_addr] || i_mod_just);
        w_turbo_new = r_turbo[i_addr] ^ (w_upd && i_mod_held);
        if (!i_btn) begin
            n_div = i_now;
        end else if (w_upd) begin
            n_div = '0;
        end else begin
            n_div = i_now - w_pf;
        end
    end

    assign w_period = {1'b0, i_tap} + 9'd1;
    assign w_trial  = {r_rem, r_div[FRAME_W-1]};

    // held and turbo bits, cleared at once by reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_held  <= '0;
            r_turbo <= '0;
        end else if (i_ctl.ld) begin
            r_held[i_addr]  <= i_btn;
            r_turbo[i_addr] <= w_turbo_new;
        end
    end

    // restoring remainder, one dividend bit per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_div       <= n_div;
            r_rem       <= '0;
            r_drive     <= w_turbo_new && (i_btn || i_auto_tap || i_auto_hold);
            r_tog       <= w_upd && i_mod_held;
            r_turbo_bit <= w_turbo_new;
            r_bit       <= i_btn;
        end else if (i_ctl.step) begin
            r_div <= {r_div[FRAME_W-2:0], 1'b0};
            if (w_trial >= w_period) begin
                r_rem <= 8'(w_trial - w_period);
            end else begin
                r_rem <= w_trial[7:0];
            end
        end
    end

    // gate the button by the pulse phase
    always_comb begin
        o_res.out_bit = r_drive ? (({1'b0, r_rem} < (w_period >> 1)) || i_auto_hold) : r_bit;
        o_res.toggled = r_tog;
        o_res.turbo   = r_turbo_bit;
    end
endmodule

// ===== hdl/turbo_autofire_button_gate.sv =====
// turbo_autofire_button_gate: top level, sequencer, merge of lane results and output register
// depends on tabg_pkg and tabg_lane
//
// Usage:
//   The slave stream takes one word per device frame: tuser is the operation
//   (process or clear), tdata carries device, button mask, frame number and
//   the two modifier flags. The master stream returns one word per input
//   word: gated buttons, toggled mask and turbo mask.
//   Eight lanes each handle one button at a time; a lane runs a bit-serial
//   remainder of the 64-bit frame difference by the turbo period, one bit per
//   cycle. A process word for a valid device runs, for each of ceil(BUTTONS/8)
//   groups of eight buttons, a read, a load, the modulo steps and a collect
//   state, then a finish state; clear words and out-of-range devices go
//   straight to the finish state. One word is in work at a time; the next is
//   accepted once the result sits in the output register.
//   Reset clears all held and turbo bits and loads the default registers;
//   press frames need no clearing since a released button masks them.
//   When the receiver stalls, the result waits in the output register and
//   the block takes one more word, holding its finished result until the
//   register frees.
//   The user must write configuration only while no word is in work; the block does not enforce this.
module turbo_autofire_button_gate #(
    parameter int DEVICES = 8,
    parameter int BUTTONS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [7:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // device_index[2:0], buttons_in[34:3], frame_count[98:35],
    // modifier_held[99], modifier_just_held[100], zero pad
    input  logic [103:0] s_axis_tdata,
    // operation[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // buttons_out[31:0], toggled_mask[63:32], turbo_mask[95:64]
    output logic [95:0]  m_axis_tdata
);
    import tabg_pkg::*;

    localparam int KPL   = (BUTTONS + LANES - 1) / LANES;
    localparam int KW    = (KPL > 1) ? $clog2(KPL) : 1;
    localparam int DEPTH = DEVICES * KPL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_LD   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_COL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [KW-1:0] r_k, n_k;
    logic [7:0]  r_tap;
    logic        r_auto_tap;
    logic        r_auto_hold;
    logic [2:0]  r_dev;
    logic [31:0] r_btn;
    logic [63:0] r_now;
    logic        r_mh;
    logic        r_mj;
    logic [31:0] r_acc_out, n_acc_out;
    logic [31:0] r_acc_tog, n_acc_tog;
    logic [31:0] r_acc_trb, n_acc_trb;
    logic        r_ovalid;
    logic [95:0] r_odata;
    logic        w_accept;
    logic        w_dev_ok;
    logic        w_load_out;
    logic [AW-1:0] w_addr;
    t_lane_ctl   w_ctl;
    t_lane_res   w_res [LANES];
    logic [LANES-1:0] w_lane_btn;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_dev_ok      = int'(s_axis_tdata[2:0]) < DEVICES;
    assign w_load_out    = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);
    assign w_addr        = AW'(int'(r_dev) * KPL + int'(r_k));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap       <= 8'd5;
            r_auto_tap  <= 1'b0;
            r_auto_hold <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TAP_INTERVAL: r_tap       <= i_cfg_wdata;
                CFG_AUTO_TAP:     r_auto_tap  <= i_cfg_wdata[0];
                CFG_AUTO_HOLD:    r_auto_hold <= i_cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // lane strobes
    always_comb begin
        w_ctl.clr  = w_accept && (s_axis_tuser == OP_CLEAR);
        w_ctl.ld   = (r_state == S_LD);
        w_ctl.step = (r_state == S_MOD);
    end

    // lanes, lane l handles buttons k*LANES+l
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_lane_btn[l] = r_btn[5'(int'(r_k) * LANES + l)];
        tabg_lane #(.DEPTH(DEPTH), .AW(AW)) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_addr     (w_addr),
            .i_btn      (w_lane_btn[l]),
            .i_now      (r_now),
            .i_mod_held (r_mh),
            .i_mod_just (r_mj),
            .i_tap      (r_tap),
            .i_auto_tap (r_auto_tap),
            .i_auto_hold(r_auto_hold),
            .o_res      (w_res[l])
        );
    end

    // sequencer and merge of lane results
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_acc_out = r_acc_out;
        n_acc_tog = r_acc_tog;
        n_acc_trb = r_acc_trb;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_k       = '0;
                    n_acc_tog = '0;
                    n_acc_trb = '0;
                    if (s_axis_tuser == OP_CLEAR) begin
                        n_acc_out = '0;
                        n_state   = S_FIN;
                    end else begin
                        n_acc_out = s_axis_tdata[34:3];
                        n_state   = w_dev_ok ? S_RD : S_FIN;
                    end
                end
            end
            S_RD: n_state = S_LD;
            S_LD: begin
                n_cnt   = '0;
                n_state = S_MOD;
            end
            S_MOD: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                for (int l = 0; l < LANES; l++) begin
                    if (int'(r_k) * LANES + l < BUTTONS) begin
                        n_acc_out[5'(int'(r_k) * LANES + l)] = w_res[l].out_bit;
                        n_acc_tog[5'(int'(r_k) * LANES + l)] = w_res[l].toggled;
                        n_acc_trb[5'(int'(r_k) * LANES + l)] = w_res[l].turbo;
                    end
                end
                if (r_k == KW'(KPL - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt     <= n_cnt;
        r_k       <= n_k;
        r_acc_out <= n_acc_out;
        r_acc_tog <= n_acc_tog;
        r_acc_trb <= n_acc_trb;
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dev <= s_axis_tdata[2:0];
            r_btn <= s_axis_tdata[34:3];
            r_now <= s_axis_tdata[98:35];
            r_mh  <= s_axis_tdata[99];
            r_mj  <= s_axis_tdata[100];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (w_load_out) begin
            r_odata <= {r_acc_trb, r_acc_tog, r_acc_out};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

// ===== hdl/tabg_check.sv =====
// tabg_check: port-level assertions for the turbo autofire button gate, bound to the top level
// depends on turbo_autofire_button_gate
module tabg_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata
);
    // a stalled word stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped under stall");

    // a stalled word keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed under stall");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");
endmodule

bind turbo_autofire_button_gate tabg_check u_tabg_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== test/tb_turbo_autofire_button_gate.sv =====
// tb_turbo_autofire_button_gate: self-checking testbench of the turbo autofire button gate
// depends on tabg_pkg and turbo_autofire_button_gate; directed table then random words
`timescale 1ns / 100ps

module tb_turbo_autofire_button_gate;
    import tabg_pkg::*;

    localparam int NDEV = 8;
    localparam int NBTN = 32;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic        op;
        logic [2:0]  dev;
        logic [31:0] btn;
        logic [63:0] frame;
        logic        mod_held;
        logic        mod_just;
    } t_word_in;

    typedef struct packed {
        logic [31:0] buttons;
        logic [31:0] toggled;
        logic [31:0] turbo;
    } t_word_out;

    // directed row: input word, and optionally a typed-in result
    typedef struct {
        t_word_in  w;
        bit        fixed;
        t_word_out res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [7:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;

    turbo_autofire_button_gate #(.DEVICES(NDEV), .BUTTONS(NBTN)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [63:0] pm_press [NDEV*NBTN];
    bit          pm_turbo [NDEV*NBTN];
    bit          pm_held  [NDEV*NBTN];
    logic [7:0]  pm_interval;
    bit          pm_auto_tap;
    bit          pm_auto_hold;

    t_word_out   gated_q[$];
    int          mismatches = 0;
    bit          failed = 0;
    int          quiet = 0;
    bit          no_idle = 0;
    int          out_idle = 0;

    function automatic void gate_reset();
        for (int i = 0; i < NDEV*NBTN; i++) begin
            pm_press[i] = '0; pm_turbo[i] = 0; pm_held[i] = 0;
        end
    endfunction

    function automatic bit pulse(logic [63:0] now, logic [63:0] start);
        logic [63:0] period;
        logic [63:0] phase;
        period = {56'd0, pm_interval} + 64'd1;
        phase = (now - start) % period;
        return (phase < (period >> 1)) || pm_auto_hold;
    endfunction

    function automatic t_word_out gate_predict(t_word_in w);
        t_word_out r;
        int s;
        r.buttons = w.btn; r.toggled = '0; r.turbo = '0;
        if (w.op == OP_CLEAR) begin
            gate_reset();
            return '0;
        end
        for (int b = 0; b < NBTN; b++) begin
            s = w.dev * NBTN + b;
            if (w.btn[b]) begin
                if (!pm_held[s] || w.mod_just) begin
                    pm_held[s] = 1; pm_press[s] = w.frame;
                    if (w.mod_held) begin
                        pm_turbo[s] ^= 1; r.toggled[b] = 1'b1;
                    end
                end
                if (pm_turbo[s]) r.buttons[b] = pulse(w.frame, pm_press[s]);
            end else begin
                pm_held[s] = 0; pm_press[s] = '0;
                if (pm_turbo[s] && (pm_auto_tap || pm_auto_hold))
                    r.buttons[b] = pulse(w.frame, 64'd0);
            end
            r.turbo[b] = pm_turbo[s];
        end
        return r;
    endfunction

    // result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_word_out got, exp_r;
            // buttons in the low bits of the word, turbo mask on top
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]};
            if (gated_q.size() == 0) begin
                failed = 1;
                if (mismatches < 10) $display("unexpected word %h", got);
                mismatches++;
            end else begin
                exp_r = gated_q.pop_front();
                if (got !== exp_r) begin
                    failed = 1;
                    if (mismatches < 10)
                        $display("mismatch exp %h %h %h got %h %h %h",
                                 exp_r.buttons, exp_r.toggled, exp_r.turbo,
                                 got.buttons, got.toggled, got.turbo);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on accepted and delivered words
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else if (i_rst_n && (s_axis_tvalid || gated_q.size() != 0))
            quiet++;
        if (quiet >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (no_idle) m_axis_tready <= 1'b1;
        else if (out_idle > 0) begin
            out_idle--; m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            out_idle = $urandom_range(1, 10); m_axis_tready <= 1'b0;
        end else m_axis_tready <= 1'b1;
    end

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TAP_INTERVAL: pm_interval = val;
            CFG_AUTO_TAP:     pm_auto_tap = val[0];
            CFG_AUTO_HOLD:    pm_auto_hold = val[0];
            default: ;
        endcase
    endtask

    // wait until every expected word is out, then a latency margin
    task automatic drain();
        while (gated_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // send one word; called at a falling edge, returns at a falling edge
    task automatic send_word(t_word_in w, bit fixed, t_word_out res);
        t_word_out p;
        // block is busy right after an accept, so step past the release edge
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        p = gate_predict(w);
        gated_q.push_back(fixed ? res : p);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.op;
        s_axis_tdata <= {3'b000, w.mod_just, w.mod_held, w.frame, w.btn, w.dev};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic t_word_in rand_word(int seq_dev, logic [31:0] prev, logic [63:0] fr);
        t_word_in w;
        w.op = ($urandom_range(0, 60) == 0) ? OP_CLEAR : OP_PROCESS;
        w.dev = seq_dev[2:0];
        // mostly hold previous buttons, else flip one bit or draw a new mask
        case ($urandom_range(0, 3))
            0: w.btn = $urandom;
            1: w.btn = prev ^ (32'd1 << $urandom_range(0, 31));
            default: w.btn = prev;
        endcase
        w.frame = ($urandom_range(0, 20) == 0) ? {$urandom, $urandom} : fr;
        w.mod_held = ($urandom_range(0, 4) == 0);
        w.mod_just = w.mod_held && ($urandom_range(0, 1) == 0);
        if ($urandom_range(0, 30) == 0) w.mod_just = 1;
        return w;
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        logic [31:0] prev [NDEV];
        logic [63:0] fr;
        int d;

        pm_interval = 8'd5; pm_auto_tap = 0; pm_auto_hold = 0;
        gate_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        r.fixed = 1;
        r.w = '{OP_PROCESS, 3'd0, 32'hFFFF_FFFF, 64'd0, 1'b0, 1'b0};
        r.res = '{32'hFFFF_FFFF, 32'd0, 32'd0}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd7, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0};
        r.res = '0; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'h8000_0001, 64'd10, 1'b1, 1'b1};
        r.res = '{32'h8000_0001, 32'h8000_0001, 32'h8000_0001}; rows.push_back(r);
        r.fixed = 0;
        r.w = '{OP_PROCESS, 3'd1, 32'h8000_0001, 64'd13, 1'b0, 1'b0}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'h8000_0001, 64'd14, 1'b0, 1'b0}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'h0000_0000, 64'd15, 1'b0, 1'b0}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'h5555_5555, 64'd5, 1'b1, 1'b1}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'hAAAA_AAAA, 64'd2, 1'b1, 1'b0}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'hFFFF_FFFF, 64'd1, 1'b0, 1'b1}; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0};
        rows.push_back(r);
        r.fixed = 1;
        r.w = '{OP_CLEAR, 3'd1, 32'hFFFF_FFFF, 64'd3, 1'b1, 1'b1};
        r.res = '0; rows.push_back(r);
        r.w = '{OP_PROCESS, 3'd1, 32'h0000_00FF, 64'd4, 1'b0, 1'b0};
        r.res = '{32'h0000_00FF, 32'd0, 32'd0}; rows.push_back(r);
        foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].res);
        drain();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: cfg_write(CFG_TAP_INTERVAL, 8'd1);
                1: cfg_write(CFG_TAP_INTERVAL, 8'd240);
                2: cfg_write(CFG_TAP_INTERVAL, 8'd0);
                3: cfg_write(CFG_TAP_INTERVAL, 8'd255);
                default: cfg_write(CFG_TAP_INTERVAL, 8'($urandom_range(1, 12)));
            endcase
            cfg_write(CFG_AUTO_TAP, 8'($urandom_range(0, 1)) | (ph == 5 ? 8'hFE : 8'h0));
            cfg_write(CFG_AUTO_HOLD, (ph == 6) ? 8'd1 : 8'd0);
            if (ph == 7) no_idle = 1;
            for (int i = 0; i < NDEV; i++) prev[i] = $urandom;
            fr = {$urandom, $urandom};
            for (int n = 0; n < 245; n++) begin
                d = $urandom_range(0, NDEV - 1);
                fr = fr + 64'($urandom_range(0, 3));
                r.w = rand_word(d, prev[d], fr);
                prev[d] = r.w.btn;
                send_word(r.w, 0, '0);
            end
            drain();
        end

        if (failed || gated_q.size() != 0) begin
            $display("status: fail");
        end else begin
            $display("status: pass");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tabg_pkg.sv
hdl/tabg_ram.sv
hdl/tabg_lane.sv
hdl/turbo_autofire_button_gate.sv
hdl/tabg_check.sv
test/tb_turbo_autofire_button_gate.sv
